FILE: src/bcog_pkg.sv
// Box cell offset generator: shared constants, codes, controller/datapath types
// and bound-decoding helpers.
// No dependencies.
package bcog_pkg;

   localparam int IO_DIMS        = 4;
   localparam int DEF_MAX_DIMS   = 4;
   localparam int DEF_COORD_BITS = 32;
   localparam int OFF_W          = 64;
   localparam int EXT_W          = 33;
   localparam int PROD_W         = OFF_W + EXT_W;
   localparam int DIM_W          = 2;
   localparam int DCNT_FIELD_W   = 3;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_W          = 64;
   localparam int MCNT_W         = $clog2(EXT_W + 1);
   localparam int DCNT_W         = $clog2(OFF_W + 1);

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_DIM_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOUNDS_BASE = 3'd1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_MUL_ACC,
      OP_SET_LAST,
      OP_MUL_STRIDE,
      OP_MUL_COUNT,
      OP_CHECK_CNT,
      OP_DIV,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [DIM_W-1:0] dim;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0] last_dim;
      logic             in_range;
      logic             mul_done;
      logic             div_quick;
      logic             div_done;
      logic             over;
      logic             out_free;
   } stat_type;

   function automatic logic signed [OFF_W-1:0] bnd_lo(input logic [CSR_W-1:0] b);
      logic signed [31:0] l;
      l = b[31:0];
      return l;
   endfunction

   function automatic logic signed [OFF_W-1:0] bnd_hi(input logic [CSR_W-1:0] b);
      logic signed [31:0] h;
      h = b[63:32];
      return h;
   endfunction

   function automatic logic [EXT_W-1:0] bnd_extent(input logic [CSR_W-1:0] b);
      logic signed [EXT_W-1:0] lo;
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] df;
      lo = signed'({b[31], b[31:0]});
      hi = signed'({b[63], b[63:32]});
      df = hi - lo;
      if (df < 0) begin
         return '0;
      end
      return EXT_W'(df) + EXT_W'(1);
   endfunction

endpackage

FILE: src/bcog_if.sv
// Box cell offset generator: request and response channel interfaces.
// Depends on bcog_pkg.
interface bcog_req_if #(
   parameter int COORD_BITS = bcog_pkg::DEF_COORD_BITS
) ();
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] coord_a;
   logic signed [COORD_BITS-1:0] coord_b;
   logic signed [COORD_BITS-1:0] coord_c;
   logic signed [COORD_BITS-1:0] coord_d;
   logic [bcog_pkg::OFF_W-1:0]   linear_offset;

   modport source(output valid, kind, coord_a, coord_b, coord_c, coord_d, linear_offset,
                  input ready);
   modport sink(input valid, kind, coord_a, coord_b, coord_c, coord_d, linear_offset,
                output ready);
endinterface

interface bcog_rsp_if #(
   parameter int COORD_BITS = bcog_pkg::DEF_COORD_BITS
) ();
   logic                         valid;
   logic                         ready;
   logic [bcog_pkg::OFF_W-1:0]   result_offset;
   logic signed [COORD_BITS-1:0] out_a;
   logic signed [COORD_BITS-1:0] out_b;
   logic signed [COORD_BITS-1:0] out_c;
   logic signed [COORD_BITS-1:0] out_d;
   logic [1:0]                   status;
   logic [1:0]                   bad_dim;

   modport source(output valid, result_offset, out_a, out_b, out_c, out_d, status, bad_dim,
                  input ready);
   modport sink(input valid, result_offset, out_a, out_b, out_c, out_d, status, bad_dim,
                output ready);
endinterface

FILE: src/bcog_ctrl.sv
// Box cell offset generator: sequencing state machine.
// Depends on bcog_pkg; drives bcog_dp through cmd_type, reads stat_type.
module bcog_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_kind,
   output logic               req_ready,
   output bcog_pkg::cmd_type  cmd,
   input  bcog_pkg::stat_type stat
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_CHECK     = 13'b0000000000010,
      S_MUL       = 13'b0000000000100,
      S_MWAIT_ACC = 13'b0000000001000,
      S_SETUP     = 13'b0000000010000,
      S_STRIDE    = 13'b0000000100000,
      S_MWAIT_STR = 13'b0000001000000,
      S_COUNT     = 13'b0000010000000,
      S_MWAIT_CNT = 13'b0000100000000,
      S_CHECK_CNT = 13'b0001000000000,
      S_DIV       = 13'b0010000000000,
      S_DWAIT     = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [bcog_pkg::DIM_W-1:0]     dim_ff, dim_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dim_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dim_in    = dim_ff;
      cmd.op    = bcog_pkg::OP_NONE;
      cmd.dim   = dim_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bcog_pkg::OP_LOAD;
               dim_in   = '0;
               state_in = req_kind ? S_SETUP : S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op = bcog_pkg::OP_CHECK;
            if (!stat.in_range || dim_ff == stat.last_dim) begin
               state_in = S_DONE;
            end else begin
               dim_in   = dim_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op   = bcog_pkg::OP_MUL_ACC;
            state_in = S_MWAIT_ACC;
         end
         S_MWAIT_ACC: begin
            if (stat.mul_done) begin
               state_in = S_CHECK;
            end
         end
         S_SETUP: begin
            cmd.op   = bcog_pkg::OP_SET_LAST;
            dim_in   = stat.last_dim;
            state_in = (stat.last_dim == '0) ? S_COUNT : S_STRIDE;
         end
         S_STRIDE: begin
            cmd.op   = bcog_pkg::OP_MUL_STRIDE;
            state_in = S_MWAIT_STR;
         end
         S_MWAIT_STR: begin
            if (stat.mul_done) begin
               if (dim_ff == bcog_pkg::DIM_W'(1)) begin
                  state_in = S_COUNT;
               end else begin
                  dim_in   = dim_ff - 1'b1;
                  state_in = S_STRIDE;
               end
            end
         end
         S_COUNT: begin
            cmd.op   = bcog_pkg::OP_MUL_COUNT;
            cmd.dim  = '0;
            state_in = S_MWAIT_CNT;
         end
         S_MWAIT_CNT: begin
            if (stat.mul_done) begin
               state_in = S_CHECK_CNT;
            end
         end
         S_CHECK_CNT: begin
            cmd.op = bcog_pkg::OP_CHECK_CNT;
            dim_in = '0;
            state_in = stat.over ? S_DONE : S_DIV;
         end
         S_DIV: begin
            cmd.op = bcog_pkg::OP_DIV;
            if (stat.div_quick) begin
               if (dim_ff == stat.last_dim) begin
                  state_in = S_DONE;
               end else begin
                  dim_in = dim_ff + 1'b1;
               end
            end else begin
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (stat.div_done) begin
               if (dim_ff == stat.last_dim) begin
                  state_in = S_DONE;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.op   = bcog_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: src/bcog_dp.sv
// Box cell offset generator: datapath with bound registers, bit-serial multiplier,
// radix-2 divider and result register.
// Depends on bcog_pkg; commanded by bcog_ctrl.
module bcog_dp #(
   parameter int MAX_DIMS   = bcog_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS = bcog_pkg::DEF_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bcog_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bcog_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                  req_kind,
   input  logic [COORD_BITS-1:0]                 req_coord [bcog_pkg::IO_DIMS],
   input  logic [bcog_pkg::OFF_W-1:0]            req_offset,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [bcog_pkg::OFF_W-1:0]            rsp_offset,
   output logic [COORD_BITS-1:0]                 rsp_coord [bcog_pkg::IO_DIMS],
   output logic [1:0]                            rsp_status,
   output logic [1:0]                            rsp_bad_dim,
   input  bcog_pkg::cmd_type                     cmd,
   output bcog_pkg::stat_type                    stat
);

   localparam int ND  = bcog_pkg::IO_DIMS;
   localparam int OW  = bcog_pkg::OFF_W;
   localparam int PW  = bcog_pkg::PROD_W;
   localparam int EW  = bcog_pkg::EXT_W;
   localparam int CAP = (MAX_DIMS < ND) ? MAX_DIMS : ND;

   logic [bcog_pkg::DCNT_FIELD_W-1:0] dim_count_ff;
   logic [bcog_pkg::CSR_W-1:0]        bounds_ff [ND];

   logic                    kind_ff;
   logic [COORD_BITS-1:0]   coord_ff [ND];
   logic [OW-1:0]           acc_ff;
   logic [OW-1:0]           stride_ff [ND];
   logic                    ssat_ff [ND];
   logic [OW-1:0]           count_ff;
   logic                    csat_ff;
   logic [COORD_BITS-1:0]   res_ff [ND];
   logic [1:0]              status_ff;
   logic [1:0]              bad_ff;

   logic                          mbusy_ff;
   logic [bcog_pkg::MCNT_W-1:0]   mcnt_ff;
   logic [PW-1:0]                 mcand_ff;
   logic [EW-1:0]                 mplier_ff;
   logic [PW-1:0]                 mprod_ff;
   logic                          masat_ff;
   logic                          mbnz_ff;
   bcog_pkg::op_type              mop_ff;
   logic [bcog_pkg::DIM_W-1:0]    mdim_ff;

   logic                          dbusy_ff;
   logic [bcog_pkg::DCNT_W-1:0]   dcnt_ff;
   logic [OW-1:0]                 dquo_ff;
   logic [OW-1:0]                 drem_ff;
   logic [OW-1:0]                 ddiv_ff;
   logic [OW-1:0]                 dlo_ff;
   logic [bcog_pkg::DIM_W-1:0]    ddim_ff;

   logic                    ov_ff;
   logic [OW-1:0]           o_off_ff;
   logic [COORD_BITS-1:0]   o_coord_ff [ND];
   logic [1:0]              o_status_ff;
   logic [1:0]              o_bad_ff;

   logic [bcog_pkg::DCNT_FIELD_W-1:0] n_used;
   logic [bcog_pkg::DIM_W-1:0]        last_dim;
   logic [bcog_pkg::CSR_W-1:0]        bsel;
   logic signed [OW-1:0]              lo_sel, hi_sel, p64;
   logic signed [COORD_BITS-1:0]      csel;
   logic [EW-1:0]                     ext_sel;
   logic [OW-1:0]                     ssel;
   logic                              in_range;
   logic                              quick;
   logic                              mul_done, div_done;
   logic                              msat;
   logic [OW-1:0]                     mval;
   logic [OW:0]                       dtrial;
   logic                              dge;
   logic [OW-1:0]                     qsum_quick, qsum_div;
   logic                              out_free;

   always_comb begin
      if (dim_count_ff == '0) begin
         n_used = bcog_pkg::DCNT_FIELD_W'(1);
      end else if (dim_count_ff > bcog_pkg::DCNT_FIELD_W'(CAP)) begin
         n_used = bcog_pkg::DCNT_FIELD_W'(CAP);
      end else begin
         n_used = dim_count_ff;
      end
   end
   assign last_dim = bcog_pkg::DIM_W'(n_used - 1'b1);

   assign bsel     = bounds_ff[cmd.dim];
   assign lo_sel   = bcog_pkg::bnd_lo(bsel);
   assign hi_sel   = bcog_pkg::bnd_hi(bsel);
   assign ext_sel  = bcog_pkg::bnd_extent(bsel);
   assign csel     = coord_ff[cmd.dim];
   assign p64      = csel;
   assign in_range = !(p64 < lo_sel || p64 > hi_sel);
   assign ssel     = stride_ff[cmd.dim];
   assign quick    = ssat_ff[cmd.dim] || ssel == '0 || ssel == OW'(1);
   assign qsum_quick = lo_sel + ((ssel == OW'(1) && !ssat_ff[cmd.dim]) ? acc_ff : '0);
   assign qsum_div   = dlo_ff + dquo_ff;

   assign mul_done = mbusy_ff && mcnt_ff == '0;
   assign msat     = mbnz_ff && (masat_ff || |mprod_ff[PW-1:OW]);
   assign mval     = msat ? '0 : mprod_ff[OW-1:0];

   assign div_done = dbusy_ff && dcnt_ff == '0;
   assign dtrial   = {drem_ff, dquo_ff[OW-1]};
   assign dge      = dtrial >= {1'b0, ddiv_ff};

   assign out_free = !ov_ff || rsp_ready;

   assign stat.last_dim  = last_dim;
   assign stat.in_range  = in_range;
   assign stat.mul_done  = mul_done;
   assign stat.div_quick = quick;
   assign stat.div_done  = div_done;
   assign stat.over      = !csat_ff && acc_ff >= count_ff;
   assign stat.out_free  = out_free;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= bcog_pkg::DCNT_FIELD_W'(1);
         for (int i = 0; i < ND; i++) begin
            bounds_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == bcog_pkg::REG_DIM_COUNT) begin
            dim_count_ff <= csr_wdata[bcog_pkg::DCNT_FIELD_W-1:0];
         end else if (csr_index >= bcog_pkg::REG_BOUNDS_BASE &&
                      csr_index < bcog_pkg::REG_BOUNDS_BASE + bcog_pkg::CSR_IDX_W'(ND)) begin
            bounds_ff[bcog_pkg::DIM_W'(csr_index - bcog_pkg::REG_BOUNDS_BASE)] <= csr_wdata;
         end
      end
   end

   // unit control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         if (cmd.op == bcog_pkg::OP_MUL_ACC || cmd.op == bcog_pkg::OP_MUL_STRIDE ||
             cmd.op == bcog_pkg::OP_MUL_COUNT) begin
            mbusy_ff <= 1'b1;
         end else if (mul_done) begin
            mbusy_ff <= 1'b0;
         end
         if (cmd.op == bcog_pkg::OP_DIV && !quick) begin
            dbusy_ff <= 1'b1;
         end else if (div_done) begin
            dbusy_ff <= 1'b0;
         end
         if (cmd.op == bcog_pkg::OP_FINISH) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      // multiplier: shift-add, one multiplier bit per cycle
      if (mbusy_ff && mcnt_ff != '0) begin
         if (mplier_ff[0]) begin
            mprod_ff <= mprod_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         mcnt_ff   <= mcnt_ff - 1'b1;
      end
      if (mul_done) begin
         case (mop_ff)
            bcog_pkg::OP_MUL_ACC: begin
               acc_ff <= mprod_ff[OW-1:0];
            end
            bcog_pkg::OP_MUL_STRIDE: begin
               stride_ff[mdim_ff - 1'b1] <= mval;
               ssat_ff[mdim_ff - 1'b1]   <= msat;
            end
            bcog_pkg::OP_MUL_COUNT: begin
               count_ff <= mval;
               csat_ff  <= msat;
            end
            default: begin
            end
         endcase
      end

      // divider: restoring, one quotient bit per cycle
      if (dbusy_ff && dcnt_ff != '0) begin
         drem_ff <= dge ? OW'(dtrial - {1'b0, ddiv_ff}) : dtrial[OW-1:0];
         dquo_ff <= {dquo_ff[OW-2:0], dge};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (div_done) begin
         acc_ff           <= drem_ff;
         res_ff[ddim_ff]  <= qsum_div[COORD_BITS-1:0];
      end

      case (cmd.op)
         bcog_pkg::OP_LOAD: begin
            kind_ff   <= req_kind;
            coord_ff  <= req_coord;
            acc_ff    <= req_kind ? req_offset : '0;
            status_ff <= bcog_pkg::ST_OK;
            bad_ff    <= '0;
            for (int i = 0; i < ND; i++) begin
               res_ff[i] <= '0;
            end
         end
         bcog_pkg::OP_CHECK: begin
            if (!in_range) begin
               status_ff <= bcog_pkg::ST_RANGE;
               bad_ff    <= cmd.dim;
            end else begin
               acc_ff <= acc_ff + OW'(p64) - OW'(lo_sel);
            end
         end
         bcog_pkg::OP_MUL_ACC, bcog_pkg::OP_MUL_STRIDE, bcog_pkg::OP_MUL_COUNT: begin
            mcand_ff  <= PW'((cmd.op == bcog_pkg::OP_MUL_ACC) ? acc_ff : ssel);
            masat_ff  <= (cmd.op == bcog_pkg::OP_MUL_ACC) ? 1'b0 : ssat_ff[cmd.dim];
            mplier_ff <= ext_sel;
            mbnz_ff   <= ext_sel != '0;
            mprod_ff  <= '0;
            mcnt_ff   <= bcog_pkg::MCNT_W'(EW);
            mop_ff    <= cmd.op;
            mdim_ff   <= cmd.dim;
         end
         bcog_pkg::OP_SET_LAST: begin
            stride_ff[last_dim] <= OW'(1);
            ssat_ff[last_dim]   <= 1'b0;
         end
         bcog_pkg::OP_CHECK_CNT: begin
            if (!csat_ff && acc_ff >= count_ff) begin
               status_ff <= bcog_pkg::ST_COUNT;
            end
         end
         bcog_pkg::OP_DIV: begin
            if (quick) begin
               res_ff[cmd.dim] <= qsum_quick[COORD_BITS-1:0];
               if (ssel == OW'(1) && !ssat_ff[cmd.dim]) begin
                  acc_ff <= '0;
               end
            end else begin
               dquo_ff <= acc_ff;
               drem_ff <= '0;
               ddiv_ff <= ssel;
               dlo_ff  <= lo_sel;
               ddim_ff <= cmd.dim;
               dcnt_ff <= bcog_pkg::DCNT_W'(OW);
            end
         end
         bcog_pkg::OP_FINISH: begin
            o_off_ff    <= (!kind_ff && status_ff == bcog_pkg::ST_OK) ? acc_ff : '0;
            o_coord_ff  <= res_ff;
            o_status_ff <= status_ff;
            o_bad_ff    <= bad_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid   = ov_ff;
   assign rsp_offset  = o_off_ff;
   assign rsp_coord   = o_coord_ff;
   assign rsp_status  = o_status_ff;
   assign rsp_bad_dim = o_bad_ff;

endmodule

FILE: src/box_cell_offset_generator.sv
// Box cell offset generator: top level joining controller, datapath and channels.
// Depends on bcog_pkg, bcog_if, bcog_ctrl and bcog_dp.

// Maps a point of a box of up to four dimensions to its row-major cell offset
// (kind 0) or an offset back to its point (kind 1), one item at a time. Kind 0
// runs, for each dimension in use after the first, the bit-serial 64x33
// multiplier that scales the running offset by each next extent. Kind 1 builds
// the strides and the cell count on that multiplier, then runs each dimension
// through the radix-2 divider; dimensions whose stride is one, zero or
// saturated skip the divider. A finished result sits in an output register,
// and the next request is taken while it waits.
module box_cell_offset_generator #(
   parameter int MAX_DIMS   = bcog_pkg::DEF_MAX_DIMS,
   parameter int COORD_BITS = bcog_pkg::DEF_COORD_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   bcog_req_if.sink                        req_if,
   bcog_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [bcog_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcog_pkg::CSR_W-1:0]      csr_wdata
);

   bcog_pkg::cmd_type         cmd;
   bcog_pkg::stat_type        stat;
   logic [COORD_BITS-1:0]     req_coord [bcog_pkg::IO_DIMS];
   logic [COORD_BITS-1:0]     rsp_coord [bcog_pkg::IO_DIMS];

   assign req_coord[0] = req_if.coord_a;
   assign req_coord[1] = req_if.coord_b;
   assign req_coord[2] = req_if.coord_c;
   assign req_coord[3] = req_if.coord_d;

   assign rsp_if.out_a = rsp_coord[0];
   assign rsp_if.out_b = rsp_coord[1];
   assign rsp_if.out_c = rsp_coord[2];
   assign rsp_if.out_d = rsp_coord[3];

   bcog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bcog_dp #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_kind    (req_if.kind),
      .req_coord   (req_coord),
      .req_offset  (req_if.linear_offset),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_offset  (rsp_if.result_offset),
      .rsp_coord   (rsp_coord),
      .rsp_status  (rsp_if.status),
      .rsp_bad_dim (rsp_if.bad_dim),
      .cmd         (cmd),
      .stat        (stat)
   );

   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != bcog_pkg::ST_OK |-> rsp_if.result_offset == '0)
      else $error("failed item carries an offset");

   a_bad_dim_only_on_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status != bcog_pkg::ST_RANGE |-> rsp_if.bad_dim == '0)
      else $error("bad_dim set without a range fault");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while an item is in flight");

endmodule
